// ===== hw/rtl/nrb_pkg.sv =====
// Shared constants, types and helper functions of the Newton root basin solver.
package nrb_pkg;

   // Number format and sizes.
   localparam int MAX_ORDER   = 8;
   localparam int FRAC_BITS   = 32;
   localparam int COORD_BITS  = 12;
   localparam int VAL_BITS    = FRAC_BITS + 16;
   localparam int ROOT_SLOTS  = (MAX_ORDER * (MAX_ORDER + 1)) / 2;
   localparam int IDX_BITS    = $clog2(ROOT_SLOTS);
   localparam int OPND_BITS   = 48;
   localparam int HALF_BITS   = OPND_BITS / 2;
   localparam int PROD_BITS   = 2 * OPND_BITS;
   localparam int SQ_BITS     = PROD_BITS + 1;
   localparam int NUM_BITS    = PROD_BITS + 2;
   localparam int QUO_BITS    = VAL_BITS - 1;
   localparam int ITER_BITS   = 10;
   localparam int ORDER_BITS  = 4;
   localparam int K_BITS      = 3;
   localparam int CSR_IDX_BITS = 4;
   localparam int CSR_DATA_BITS = 48;

   typedef logic signed [VAL_BITS-1:0] val_type;
   typedef logic [ROOT_SLOTS-1:0][2*VAL_BITS-1:0] root_tab_type;

   localparam logic signed [63:0] VAL_MAX = (64'sd1 <<< (VAL_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] VAL_MIN = -VAL_MAX - 64'sd1;
   localparam logic signed [63:0] ONE_FIX = 64'sd1 <<< FRAC_BITS;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_BITS-1:0] CSR_ORDER     = 4'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_ITER  = 4'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TOLERANCE = 4'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DERIV_FLR = 4'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_X_ORIGIN  = 4'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_Y_ORIGIN  = 4'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_X_STEP    = 4'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_Y_STEP    = 4'd7;

   // Sequencer states.
   typedef enum logic [4:0] {
      S_IDLE, S_MAP_X, S_MAP_Y, S_TOL, S_FLR, S_ITER, S_CHK_RE, S_CHK_IM,
      S_POW, S_C_RR, S_C_II, S_C_RI, S_C_IR, S_DERIV, S_DEN_R, S_DEN_I,
      S_NUM_A, S_NUM_B, S_NUM_C, S_NUM_D, S_DIV_RE, S_DIV_IM, S_DONE
   } state_type;

   // Saturate a wide signed value to the stored range.
   function automatic val_type sat_val(input logic signed [63:0] v);
      if (v > VAL_MAX) return val_type'(VAL_MAX);
      else if (v < VAL_MIN) return val_type'(VAL_MIN);
      else return val_type'(v);
   endfunction

   // Magnitude of a stored value as an unsigned operand.
   function automatic logic [OPND_BITS-1:0] abs_val(input val_type v);
      logic [VAL_BITS-1:0] neg;
      neg = VAL_BITS'(-v);
      return v[VAL_BITS-1] ? OPND_BITS'(neg) : OPND_BITS'(v);
   endfunction

   // Fixed-point product from a magnitude product: truncate, sign, saturate.
   function automatic val_type smul_fix(input logic [PROD_BITS-1:0] prod, input logic neg);
      logic [PROD_BITS-FRAC_BITS-1:0] m;
      m = prod[PROD_BITS-1:FRAC_BITS];
      if (neg) begin
         if (m > (PROD_BITS-FRAC_BITS)'(VAL_MAX)) return val_type'(VAL_MIN);
         else return val_type'(-$signed({1'b0, m}));
      end else begin
         if (m > (PROD_BITS-FRAC_BITS)'(VAL_MAX)) return val_type'(VAL_MAX);
         else return val_type'(m);
      end
   endfunction

   // Small multiple of a value by shift and add, then saturated.
   function automatic val_type times_small(input logic [ORDER_BITS-1:0] n, input val_type p);
      logic signed [63:0] acc;
      logic signed [63:0] ext;
      acc = 64'sd0;
      ext = 64'(p);
      for (int i = 0; i < ORDER_BITS; i++) begin
         if (n[i]) acc = acc + (ext <<< i);
      end
      return sat_val(acc);
   endfunction

   // Elaboration-time helpers that build the unit-root table.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] d);
      logic [64:0] rem;
      logic [63:0] q;
      rem = '0;
      q = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, d}) begin
            rem = rem - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] mul60(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[123:60];
   endfunction

   function automatic logic [63:0] to_frac(input logic [63:0] v);
      logic [63:0] t;
      t = v + (64'd1 << (59 - FRAC_BITS));
      return t >> (60 - FRAC_BITS);
   endfunction

   function automatic logic [2*VAL_BITS-1:0] unit_root(input int k, input int n);
      logic [63:0] a, oct, r, t, x, x2, s, c, term, cs, sn, st, re, im, m;
      a = 64'(8 * k);
      oct = udiv64(a, 64'(n));
      r = a - oct * 64'(n);
      t = oct[0] ? 64'(n) - r : r;
      x = udiv64(64'h0C90FDAA22168C23 * t, 64'(n));
      x2 = mul60(x, x);
      s = x;
      term = x;
      for (int i = 1; i <= 12; i++) begin
         term = udiv64(mul60(term, x2), 64'((2 * i) * (2 * i + 1)));
         s = (i % 2 == 1) ? s - term : s + term;
      end
      c = 64'd1 << 60;
      term = 64'd1 << 60;
      for (int i = 1; i <= 12; i++) begin
         term = udiv64(mul60(term, x2), 64'((2 * i - 1) * (2 * i)));
         c = (i % 2 == 1) ? c - term : c + term;
      end
      cs = to_frac(c);
      sn = to_frac(s);
      m = (oct >> 1) + (oct & 64'd1);
      st = oct[0] ? -sn : sn;
      case (m[1:0])
         2'd0: begin re = cs; im = st; end
         2'd1: begin re = -st; im = cs; end
         2'd2: begin re = -cs; im = -st; end
         default: begin re = st; im = -cs; end
      endcase
      return {re[VAL_BITS-1:0], im[VAL_BITS-1:0]};
   endfunction

   function automatic root_tab_type build_root_tab();
      root_tab_type tab;
      tab = '0;
      for (int n = 1; n <= MAX_ORDER; n++) begin
         for (int k = 0; k < n; k++) begin
            tab[(n - 1) * n / 2 + k] = unit_root(k, n);
         end
      end
      return tab;
   endfunction

   // Unit roots of every order, real part high, imaginary part low.
   localparam root_tab_type ROOT_TAB = build_root_tab();

endpackage

// ===== hw/rtl/nrb_mul.sv =====
// Multi-cycle unsigned 48 by 48 multiplier built from one 24 by 24 multiplier.
module nrb_mul import nrb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [OPND_BITS-1:0] opa,
   input  logic [OPND_BITS-1:0] opb,
   output logic                 done,
   output logic [PROD_BITS-1:0] prod
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [1:0]           cnt_ff, cnt_in;
   logic [OPND_BITS-1:0] a_ff, a_in, b_ff, b_in;
   logic [PROD_BITS-1:0] acc_ff, acc_in;
   logic [HALF_BITS-1:0] a_half, b_half;
   logic [2*HALF_BITS-1:0] part;
   logic [PROD_BITS-1:0] part_sh;

   // One partial product per cycle, low halves first.
   always_comb begin
      a_half = cnt_ff[1] ? a_ff[OPND_BITS-1:HALF_BITS] : a_ff[HALF_BITS-1:0];
      b_half = cnt_ff[0] ? b_ff[OPND_BITS-1:HALF_BITS] : b_ff[HALF_BITS-1:0];
      part = a_half * b_half;
      case (cnt_ff)
         2'd0:    part_sh = PROD_BITS'(part);
         2'd3:    part_sh = PROD_BITS'(part) << (2 * HALF_BITS);
         default: part_sh = PROD_BITS'(part) << HALF_BITS;
      endcase
   end

   // Load operands on start, then accumulate four partial products.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 2'd0;
         a_in    = opa;
         b_in    = opb;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = acc_ff + part_sh;
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

// ===== hw/rtl/nrb_div.sv =====
// Restoring divider giving a saturated Q15.32 quotient one bit per cycle.
module nrb_div import nrb_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [PROD_BITS-1:0] mag,
   input  logic [PROD_BITS-1:0] den,
   output logic                 done,
   output logic [QUO_BITS-1:0]  quo
);

   localparam int CNT_BITS = $clog2(QUO_BITS);
   localparam int HI_SKIP  = QUO_BITS - FRAC_BITS;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 over_ff, over_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [PROD_BITS-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [QUO_BITS-1:0]  src_ff, src_in, q_ff, q_in;
   logic [PROD_BITS-1:0] rem0;
   logic [PROD_BITS:0]   trial;

   // The top of the dividend is the starting remainder; a remainder that
   // already reaches the divisor means the quotient overflows.
   assign rem0  = PROD_BITS'(mag >> HI_SKIP);
   assign trial = {rem_ff, src_ff[QUO_BITS-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      over_in = over_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      src_in  = src_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         over_in = (rem0 >= den);
         cnt_in  = '0;
         rem_in  = rem0;
         den_in  = den;
         src_in  = {mag[HI_SKIP-1:0], {FRAC_BITS{1'b0}}};
         q_in    = '0;
      end else if (busy_ff) begin
         src_in = src_ff << 1;
         if (trial >= {1'b0, den_ff}) begin
            rem_in = PROD_BITS'(trial - {1'b0, den_ff});
            q_in   = {q_ff[QUO_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[PROD_BITS-1:0];
            q_in   = {q_ff[QUO_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_BITS'(QUO_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      over_ff <= over_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      src_ff  <= src_in;
      q_ff    <= q_in;
   end

   assign done = done_ff;
   assign quo  = over_ff ? {QUO_BITS{1'b1}} : q_ff;

endmodule

// ===== hw/rtl/newton_root_basin_solver.sv =====
// Newton root basin solver: configuration, sequencer and fixed-point datapath.
// Each multiply runs on the shared 24x24 multiplier and each of the two
// divisions on the shared restoring divider.
// One request at a time; synchronous active-high reset returns to idle and
// loads the default configuration.
module newton_root_basin_solver import nrb_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [COORD_BITS-1:0]    req_pixel_column,
   input  logic [COORD_BITS-1:0]    req_pixel_row,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_converged,
   output logic [K_BITS-1:0]        rsp_root_index,
   output logic [ITER_BITS-1:0]     rsp_iteration_count,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   localparam logic [58:0] MAP_CAP = 59'd1 << 58;

   // Configuration registers.
   logic [ORDER_BITS-1:0] order_ff;
   logic [ITER_BITS-1:0]  max_iter_ff;
   logic [46:0]           tol_ff, flr_ff, x_step_ff, y_step_ff;
   val_type               x_org_ff, y_org_ff;

   // Sequencer and datapath registers.
   state_type             state_ff, state_in;
   logic                  issued_ff, issued_in;
   logic [COORD_BITS-1:0] col_ff, col_in, row_ff, row_in;
   logic [ORDER_BITS-1:0] n_ff, n_in;
   logic [IDX_BITS-1:0]   base_ff, base_in;
   logic [K_BITS-1:0]     k_ff, k_in;
   logic [ORDER_BITS-1:0] j_ff, j_in;
   logic                  fzph_ff, fzph_in;
   logic [ITER_BITS-1:0]  iter_ff, iter_in;
   val_type               zre_ff, zre_in, zim_ff, zim_in;
   val_type               pre_ff, pre_in, pim_ff, pim_in;
   val_type               fzre_ff, fzre_in, fzim_ff, fzim_in;
   val_type               fpre_ff, fpre_in, fpim_ff, fpim_in;
   val_type               trr_ff, trr_in, tii_ff, tii_in, tri_ff, tri_in;
   logic [SQ_BITS-1:0]    acc_ff, acc_in;
   logic [PROD_BITS-1:0]  tol2_ff, tol2_in, flr2_ff, flr2_in, den_ff, den_in;
   logic signed [NUM_BITS-1:0] nre_ff, nre_in, nim_ff, nim_in;
   logic                  conv_ff, conv_in;
   logic [K_BITS-1:0]     root_ff, root_in;
   logic [ITER_BITS-1:0]  count_ff, count_in;

   // Shared units.
   logic                  mul_start, mul_done, mul_neg;
   logic [OPND_BITS-1:0]  mul_a, mul_b;
   logic [PROD_BITS-1:0]  mul_prod;
   logic                  div_start, div_done;
   logic [PROD_BITS-1:0]  div_mag;
   logic [QUO_BITS-1:0]   div_quo;

   // Derived datapath signals.
   logic                  req_take, mul_state, div_state;
   logic [ORDER_BITS-1:0] n_clamp;
   logic [2*VAL_BITS-1:0] root_ent;
   val_type               root_re, root_im;
   logic signed [VAL_BITS:0] dr, di;
   logic [OPND_BITS-1:0]  dr_abs, di_abs;
   logic [SQ_BITS-1:0]    sq_sum;
   logic                  hit, den_small;
   val_type               sm;
   logic signed [NUM_BITS-1:0] sp;
   logic [58:0]           px_cap;
   val_type               qs;
   logic                  div_neg;

   nrb_mul u_mul (
      .clock (clock), .reset (reset), .start (mul_start),
      .opa (mul_a), .opb (mul_b), .done (mul_done), .prod (mul_prod)
   );

   nrb_div u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .mag (div_mag), .den (den_ff), .done (div_done), .quo (div_quo)
   );

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff    <= ORDER_BITS'(3);
         max_iter_ff <= ITER_BITS'(100);
         tol_ff      <= 47'd4295;
         flr_ff      <= 47'd1;
         x_org_ff    <= -48'sd8589934592;
         y_org_ff    <= 48'sd8589934592;
         x_step_ff   <= 47'd16793574;
         y_step_ff   <= 47'd16793574;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ORDER:     order_ff    <= csr_data[ORDER_BITS-1:0];
            CSR_MAX_ITER:  max_iter_ff <= csr_data[ITER_BITS-1:0];
            CSR_TOLERANCE: tol_ff      <= csr_data[46:0];
            CSR_DERIV_FLR: flr_ff      <= csr_data[46:0];
            CSR_X_ORIGIN:  x_org_ff    <= val_type'(csr_data);
            CSR_Y_ORIGIN:  y_org_ff    <= val_type'(csr_data);
            CSR_X_STEP:    x_step_ff   <= csr_data[46:0];
            CSR_Y_STEP:    y_step_ff   <= csr_data[46:0];
            default: ;
         endcase
      end
   end

   // Order clamped to the supported range.
   always_comb begin
      if (order_ff == '0) n_clamp = ORDER_BITS'(1);
      else if (order_ff > ORDER_BITS'(MAX_ORDER)) n_clamp = ORDER_BITS'(MAX_ORDER);
      else n_clamp = order_ff;
   end

   assign req_take  = req_valid && !req_stall;
   assign mul_state = (state_ff != S_IDLE) && (state_ff != S_ITER) && (state_ff != S_POW) &&
                      (state_ff != S_DERIV) && (state_ff != S_DIV_RE) &&
                      (state_ff != S_DIV_IM) && (state_ff != S_DONE);
   assign div_state = (state_ff == S_DIV_RE) || (state_ff == S_DIV_IM);
   assign mul_start = mul_state && !issued_ff;
   assign div_start = div_state && !issued_ff;

   // Root distance for the root under test.
   always_comb begin
      root_ent = ROOT_TAB[IDX_BITS'(base_ff + IDX_BITS'(k_ff))];
      root_re  = val_type'(root_ent[2*VAL_BITS-1:VAL_BITS]);
      root_im  = val_type'(root_ent[VAL_BITS-1:0]);
      dr = (VAL_BITS+1)'(zre_ff) - (VAL_BITS+1)'(root_re);
      di = (VAL_BITS+1)'(zim_ff) - (VAL_BITS+1)'(root_im);
      dr_abs = dr[VAL_BITS] ? OPND_BITS'(-dr) : OPND_BITS'(dr);
      di_abs = di[VAL_BITS] ? OPND_BITS'(-di) : OPND_BITS'(di);
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_neg = 1'b0;
      unique case (state_ff)
         S_MAP_X: begin mul_a = OPND_BITS'(col_ff); mul_b = OPND_BITS'(x_step_ff); end
         S_MAP_Y: begin mul_a = OPND_BITS'(row_ff); mul_b = OPND_BITS'(y_step_ff); end
         S_TOL:   begin mul_a = OPND_BITS'(tol_ff); mul_b = OPND_BITS'(tol_ff); end
         S_FLR:   begin mul_a = OPND_BITS'(flr_ff); mul_b = OPND_BITS'(flr_ff); end
         S_CHK_RE: begin mul_a = dr_abs; mul_b = dr_abs; end
         S_CHK_IM: begin mul_a = di_abs; mul_b = di_abs; end
         S_C_RR: begin
            mul_a = abs_val(pre_ff); mul_b = abs_val(zre_ff);
            mul_neg = pre_ff[VAL_BITS-1] ^ zre_ff[VAL_BITS-1];
         end
         S_C_II: begin
            mul_a = abs_val(pim_ff); mul_b = abs_val(zim_ff);
            mul_neg = pim_ff[VAL_BITS-1] ^ zim_ff[VAL_BITS-1];
         end
         S_C_RI: begin
            mul_a = abs_val(pre_ff); mul_b = abs_val(zim_ff);
            mul_neg = pre_ff[VAL_BITS-1] ^ zim_ff[VAL_BITS-1];
         end
         S_C_IR: begin
            mul_a = abs_val(pim_ff); mul_b = abs_val(zre_ff);
            mul_neg = pim_ff[VAL_BITS-1] ^ zre_ff[VAL_BITS-1];
         end
         S_DEN_R: begin mul_a = abs_val(fpre_ff); mul_b = abs_val(fpre_ff); end
         S_DEN_I: begin mul_a = abs_val(fpim_ff); mul_b = abs_val(fpim_ff); end
         S_NUM_A: begin
            mul_a = abs_val(fzre_ff); mul_b = abs_val(fpre_ff);
            mul_neg = fzre_ff[VAL_BITS-1] ^ fpre_ff[VAL_BITS-1];
         end
         S_NUM_B: begin
            mul_a = abs_val(fzim_ff); mul_b = abs_val(fpim_ff);
            mul_neg = fzim_ff[VAL_BITS-1] ^ fpim_ff[VAL_BITS-1];
         end
         S_NUM_C: begin
            mul_a = abs_val(fzim_ff); mul_b = abs_val(fpre_ff);
            mul_neg = fzim_ff[VAL_BITS-1] ^ fpre_ff[VAL_BITS-1];
         end
         S_NUM_D: begin
            mul_a = abs_val(fzre_ff); mul_b = abs_val(fpim_ff);
            mul_neg = fzre_ff[VAL_BITS-1] ^ fpim_ff[VAL_BITS-1];
         end
         default: ;
      endcase
   end

   // Results of the shared units as the datapath uses them.
   always_comb begin
      sq_sum    = acc_ff + SQ_BITS'(mul_prod);
      hit       = sq_sum < SQ_BITS'(tol2_ff);
      den_small = (sq_sum == '0) || (sq_sum < SQ_BITS'(flr2_ff));
      sm        = smul_fix(mul_prod, mul_neg);
      sp        = mul_neg ? -$signed(NUM_BITS'(mul_prod)) : $signed(NUM_BITS'(mul_prod));
      px_cap    = (mul_prod > PROD_BITS'(MAP_CAP)) ? MAP_CAP : mul_prod[58:0];
      div_neg   = (state_ff == S_DIV_RE) ? nre_ff[NUM_BITS-1] : nim_ff[NUM_BITS-1];
      if (state_ff == S_DIV_RE)
         div_mag = PROD_BITS'(nre_ff[NUM_BITS-1] ? -nre_ff : nre_ff);
      else
         div_mag = PROD_BITS'(nim_ff[NUM_BITS-1] ? -nim_ff : nim_ff);
      qs = div_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_take) state_in = S_MAP_X;
         S_MAP_X:  if (mul_done) state_in = S_MAP_Y;
         S_MAP_Y:  if (mul_done) state_in = S_TOL;
         S_TOL:    if (mul_done) state_in = S_FLR;
         S_FLR:    if (mul_done) state_in = S_ITER;
         S_ITER:   state_in = (iter_ff >= max_iter_ff) ? S_DONE : S_CHK_RE;
         S_CHK_RE: if (mul_done) state_in = S_CHK_IM;
         S_CHK_IM: begin
            if (mul_done) begin
               if (hit) state_in = S_DONE;
               else if (ORDER_BITS'(k_ff) + ORDER_BITS'(1) < n_ff) state_in = S_CHK_RE;
               else state_in = S_POW;
            end
         end
         S_POW:    state_in = S_C_RR;
         S_C_RR:   if (mul_done) state_in = S_C_II;
         S_C_II:   if (mul_done) state_in = S_C_RI;
         S_C_RI:   if (mul_done) state_in = S_C_IR;
         S_C_IR:   if (mul_done) state_in = fzph_ff ? S_DERIV : S_POW;
         S_DERIV:  state_in = S_DEN_R;
         S_DEN_R:  if (mul_done) state_in = S_DEN_I;
         S_DEN_I:  if (mul_done) state_in = den_small ? S_DONE : S_NUM_A;
         S_NUM_A:  if (mul_done) state_in = S_NUM_B;
         S_NUM_B:  if (mul_done) state_in = S_NUM_C;
         S_NUM_C:  if (mul_done) state_in = S_NUM_D;
         S_NUM_D:  if (mul_done) state_in = S_DIV_RE;
         S_DIV_RE: if (div_done) state_in = S_DIV_IM;
         S_DIV_IM: if (div_done) state_in = S_ITER;
         S_DONE:   if (!rsp_stall) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Datapath updates and handshake outputs.
   always_comb begin
      issued_in = issued_ff;
      col_in = col_ff;   row_in = row_ff;   n_in = n_ff;   base_in = base_ff;
      k_in = k_ff;       j_in = j_ff;       fzph_in = fzph_ff; iter_in = iter_ff;
      zre_in = zre_ff;   zim_in = zim_ff;   pre_in = pre_ff;   pim_in = pim_ff;
      fzre_in = fzre_ff; fzim_in = fzim_ff; fpre_in = fpre_ff; fpim_in = fpim_ff;
      trr_in = trr_ff;   tii_in = tii_ff;   tri_in = tri_ff;   acc_in = acc_ff;
      tol2_in = tol2_ff; flr2_in = flr2_ff; den_in = den_ff;
      nre_in = nre_ff;   nim_in = nim_ff;
      conv_in = conv_ff; root_in = root_ff; count_in = count_ff;
      req_stall = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_DONE);

      // Track an operation in flight on a shared unit.
      if (mul_start || div_start) issued_in = 1'b1;
      if (mul_done || div_done) issued_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               col_in  = req_pixel_column;
               row_in  = req_pixel_row;
               n_in    = n_clamp;
               base_in = IDX_BITS'(((n_clamp - ORDER_BITS'(1)) * n_clamp) >> 1);
               iter_in = '0;
            end
         end
         S_MAP_X: if (mul_done) zre_in = sat_val(64'(x_org_ff) + $signed({5'd0, px_cap}));
         S_MAP_Y: if (mul_done) zim_in = sat_val(64'(y_org_ff) - $signed({5'd0, px_cap}));
         S_TOL:   if (mul_done) tol2_in = mul_prod;
         S_FLR:   if (mul_done) flr2_in = mul_prod;
         S_ITER: begin
            k_in = '0;
            if (iter_ff >= max_iter_ff) begin
               conv_in  = 1'b0;
               root_in  = '0;
               count_in = iter_ff;
            end
         end
         S_CHK_RE: if (mul_done) acc_in = SQ_BITS'(mul_prod);
         S_CHK_IM: begin
            if (mul_done) begin
               if (hit) begin
                  conv_in  = 1'b1;
                  root_in  = k_ff;
                  count_in = iter_ff;
               end else if (ORDER_BITS'(k_ff) + ORDER_BITS'(1) < n_ff) begin
                  k_in = k_ff + K_BITS'(1);
               end else begin
                  pre_in  = val_type'(ONE_FIX);
                  pim_in  = '0;
                  j_in    = ORDER_BITS'(1);
                  fzph_in = 1'b0;
               end
            end
         end
         // Either another power of z or the final product giving f(z).
         S_POW: if (j_ff >= n_ff) fzph_in = 1'b1;
         S_C_RR: if (mul_done) trr_in = sm;
         S_C_II: if (mul_done) tii_in = sm;
         S_C_RI: if (mul_done) tri_in = sm;
         S_C_IR: begin
            if (mul_done) begin
               if (fzph_ff) begin
                  fzre_in = sat_val(64'(sat_val(64'(trr_ff) - 64'(tii_ff))) - ONE_FIX);
                  fzim_in = sat_val(64'(tri_ff) + 64'(sm));
               end else begin
                  pre_in = sat_val(64'(trr_ff) - 64'(tii_ff));
                  pim_in = sat_val(64'(tri_ff) + 64'(sm));
                  j_in   = j_ff + ORDER_BITS'(1);
               end
            end
         end
         S_DERIV: begin
            fpre_in = times_small(n_ff, pre_ff);
            fpim_in = times_small(n_ff, pim_ff);
         end
         S_DEN_R: if (mul_done) acc_in = SQ_BITS'(mul_prod);
         S_DEN_I: begin
            if (mul_done) begin
               den_in = PROD_BITS'(sq_sum);
               if (den_small) begin
                  conv_in  = 1'b0;
                  root_in  = '0;
                  count_in = iter_ff;
               end
            end
         end
         S_NUM_A: if (mul_done) nre_in = sp;
         S_NUM_B: if (mul_done) nre_in = nre_ff + sp;
         S_NUM_C: if (mul_done) nim_in = sp;
         S_NUM_D: if (mul_done) nim_in = nim_ff - sp;
         S_DIV_RE: if (div_done) zre_in = sat_val(64'(zre_ff) - 64'(qs));
         S_DIV_IM: begin
            if (div_done) begin
               zim_in  = sat_val(64'(zim_ff) - 64'(qs));
               iter_in = iter_ff + ITER_BITS'(1);
            end
         end
         S_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         issued_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
      end
      col_ff <= col_in;   row_ff <= row_in;   n_ff <= n_in;   base_ff <= base_in;
      k_ff <= k_in;       j_ff <= j_in;       fzph_ff <= fzph_in; iter_ff <= iter_in;
      zre_ff <= zre_in;   zim_ff <= zim_in;   pre_ff <= pre_in;   pim_ff <= pim_in;
      fzre_ff <= fzre_in; fzim_ff <= fzim_in; fpre_ff <= fpre_in; fpim_ff <= fpim_in;
      trr_ff <= trr_in;   tii_ff <= tii_in;   tri_ff <= tri_in;   acc_ff <= acc_in;
      tol2_ff <= tol2_in; flr2_ff <= flr2_in; den_ff <= den_in;
      nre_ff <= nre_in;   nim_ff <= nim_in;
      conv_ff <= conv_in; root_ff <= root_in; count_ff <= count_in;
   end

   assign rsp_converged       = conv_ff;
   assign rsp_root_index      = root_ff;
   assign rsp_iteration_count = count_ff;

endmodule

// ===== hw/rtl/nrb_check.sv =====
// Port-level checks of the Newton root basin solver, bound to the top level.
module nrb_check import nrb_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic                    rsp_converged,
   input logic [K_BITS-1:0]       rsp_root_index,
   input logic [ITER_BITS-1:0]    rsp_iteration_count
);

   // While a result waits, no new request is taken.
   a_busy_when_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken while result pending");

   // A taken request keeps the block busy in the following cycle.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall) else $error("not busy after request");

   // A miss always reports root zero.
   a_miss_root_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_converged) |-> (rsp_root_index == '0))
      else $error("root index set on a miss");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_iteration_count)))
      else $error("stalled result changed");

endmodule

bind newton_root_basin_solver nrb_check u_nrb_check (
   .clock (clock), .reset (reset), .req_valid (req_valid), .req_stall (req_stall),
   .rsp_valid (rsp_valid), .rsp_stall (rsp_stall), .rsp_converged (rsp_converged),
   .rsp_root_index (rsp_root_index), .rsp_iteration_count (rsp_iteration_count)
);

// ===== test/tb_newton_root_basin_solver.sv =====
// Self-checking testbench of the Newton root basin solver: directed table, then random phases.
`timescale 1ns / 1ps
module tb_newton_root_basin_solver;
   import nrb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [63:0] s64_t;

   localparam s64_t FIX_MAX = 64'sd140737488355327;
   localparam s64_t FIX_MIN = -FIX_MAX - 64'sd1;
   localparam s64_t ONE_Q = 64'sd1 <<< 32;
   localparam logic [46:0] U47_MAX = 47'h7FFF_FFFF_FFFF;
   localparam logic [63:0] PI_QUARTER = 64'h0C90FDAA22168C23;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE = 4'd12;
   localparam int N_DIRECTED = 19;
   localparam int N_PHASES = 12;
   localparam int PHASE_ITEMS = 25;

   typedef struct packed {
      logic [3:0] order;
      logic [9:0] max_iter;
      logic [46:0] tol;
      logic [46:0] floor_mag;
      logic signed [47:0] x_org;
      logic signed [47:0] y_org;
      logic [46:0] x_inc;
      logic [46:0] y_inc;
   } solver_cfg_t;

   typedef struct packed {
      logic conv;
      logic [2:0] root;
      logic [9:0] count;
   } outcome_t;

   typedef struct packed {
      solver_cfg_t cfg;
      logic [11:0] col;
      logic [11:0] row;
      logic typed;
      outcome_t want;
   } dir_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [COORD_BITS-1:0] req_pixel_column = '0;
   logic [COORD_BITS-1:0] req_pixel_row = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_converged;
   logic [K_BITS-1:0] rsp_root_index;
   logic [ITER_BITS-1:0] rsp_iteration_count;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   // Tag travelling with the request: whether its outcome is typed in the table.
   logic req_typed = 1'b0;
   outcome_t req_want = '0;

   solver_cfg_t cfg_now;
   s64_t unit_re [36];
   s64_t unit_im [36];
   outcome_t expected_outcomes [$];
   int error_count = 0;
   bit calm_phase = 1'b0;
   dir_row_t dir_rows [N_DIRECTED];

   newton_root_basin_solver dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Fixed-point helpers of the predictor.
   function automatic s64_t clamp(input s64_t v);
      return v > FIX_MAX ? FIX_MAX : (v < FIX_MIN ? FIX_MIN : v);
   endfunction

   function automatic logic [63:0] magnitude(input s64_t v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic s64_t fx_mul(input s64_t a, input s64_t b);
      logic [127:0] p;
      logic [95:0] m;
      s64_t r;
      p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
      m = p[127:32];
      r = (m > 96'(FIX_MAX)) ? FIX_MAX + 64'sd1 : s64_t'(m[63:0]);
      return clamp(((a < 0) != (b < 0)) ? -r : r);
   endfunction

   function automatic logic [127:0] sq_mag(input s64_t re, input s64_t im);
      return {64'd0, magnitude(re)} * {64'd0, magnitude(re)}
           + {64'd0, magnitude(im)} * {64'd0, magnitude(im)};
   endfunction

   function automatic logic signed [127:0] wide_prod(input s64_t a, input s64_t b);
      logic signed [127:0] ea;
      logic signed [127:0] eb;
      ea = a;
      eb = b;
      return ea * eb;
   endfunction

   // Quotient num / den with FRAC bits, truncated toward zero and saturated.
   function automatic s64_t fx_quot(input logic signed [127:0] num, input logic [127:0] den);
      logic [127:0] mg;
      logic [191:0] q;
      s64_t r;
      mg = num < 0 ? 128'(-num) : 128'(num);
      q = ({64'd0, mg} << 32) / {64'd0, den};
      r = (q > 192'(FIX_MAX)) ? FIX_MAX : s64_t'(q[63:0]);
      return num < 0 ? -r : r;
   endfunction

   function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[123:60];
   endfunction

   // Unit root k of order n by series on the first octant and octant symmetry.
   function automatic void make_root(input int k, input int n, output s64_t re, output s64_t im);
      logic [63:0] oct, rest, t, x, x2, s, c, term, cs, sn, st;
      int quad;
      oct = (8 * k) / n;
      rest = (8 * k) % n;
      t = oct[0] ? 64'(n) - rest : rest;
      x = PI_QUARTER * t / 64'(n);
      x2 = q60_mul(x, x);
      s = x;
      term = x;
      for (int i = 1; i <= 12; i++) begin
         term = q60_mul(term, x2) / 64'((2 * i) * (2 * i + 1));
         s = (i % 2 == 1) ? s - term : s + term;
      end
      c = 64'd1 << 60;
      term = 64'd1 << 60;
      for (int i = 1; i <= 12; i++) begin
         term = q60_mul(term, x2) / 64'((2 * i - 1) * (2 * i));
         c = (i % 2 == 1) ? c - term : c + term;
      end
      cs = (c + (64'd1 << 27)) >> 28;
      sn = (s + (64'd1 << 27)) >> 28;
      st = oct[0] ? -sn : sn;
      quad = int'(((oct >> 1) + (oct & 64'd1)) & 64'd3);
      case (quad)
         0: begin re = cs; im = st; end
         1: begin re = -st; im = cs; end
         2: begin re = -cs; im = -st; end
         default: begin re = st; im = -cs; end
      endcase
   endfunction

   // Newton iteration for one pixel under the current register settings.
   function automatic outcome_t solve_pixel(input logic [11:0] col, input logic [11:0] row);
      int n, base, it;
      logic [63:0] px, py;
      s64_t zr, zi, pr, pi, tr, fzr, fzi, fpr, fpi;
      logic [127:0] tol2, floor2, den;
      logic signed [127:0] nre, nim;
      bit hit;
      outcome_t res;
      n = cfg_now.order;
      if (n < 1) n = 1;
      if (n > 8) n = 8;
      base = (n - 1) * n / 2;
      tol2 = {81'd0, cfg_now.tol} * {81'd0, cfg_now.tol};
      floor2 = {81'd0, cfg_now.floor_mag} * {81'd0, cfg_now.floor_mag};
      px = {52'd0, col} * {17'd0, cfg_now.x_inc};
      py = {52'd0, row} * {17'd0, cfg_now.y_inc};
      if (px > (64'd1 << 58)) px = 64'd1 << 58;
      if (py > (64'd1 << 58)) py = 64'd1 << 58;
      zr = clamp(s64_t'(cfg_now.x_org) + s64_t'(px));
      zi = clamp(s64_t'(cfg_now.y_org) - s64_t'(py));
      res = '0;
      for (it = 0; it < cfg_now.max_iter; it++) begin
         hit = 1'b0;
         for (int k = 0; k < n && !hit; k++) begin
            if (sq_mag(zr - unit_re[base + k], zi - unit_im[base + k]) < tol2) begin
               hit = 1'b1;
               res.root = 3'(k);
            end
         end
         if (hit) begin
            res.conv = 1'b1;
            break;
         end
         pr = ONE_Q;
         pi = 0;
         for (int j = 1; j < n; j++) begin
            tr = clamp(fx_mul(pr, zr) - fx_mul(pi, zi));
            pi = clamp(fx_mul(pr, zi) + fx_mul(pi, zr));
            pr = tr;
         end
         fzr = clamp(clamp(fx_mul(pr, zr) - fx_mul(pi, zi)) - ONE_Q);
         fzi = clamp(fx_mul(pr, zi) + fx_mul(pi, zr));
         fpr = clamp(s64_t'(n) * pr);
         fpi = clamp(s64_t'(n) * pi);
         den = sq_mag(fpr, fpi);
         if (den == 0 || den < floor2) break;
         nre = wide_prod(fzr, fpr) + wide_prod(fzi, fpi);
         nim = wide_prod(fzi, fpr) - wide_prod(fzr, fpi);
         zr = clamp(zr - fx_quot(nre, den));
         zi = clamp(zi - fx_quot(nim, den));
      end
      if (!res.conv) res.root = 3'd0;
      res.count = 10'(it);
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      $display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
      error_count++;
   endtask

   // Predict every accepted request.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         if (req_typed) expected_outcomes.push_back(req_want);
         else expected_outcomes.push_back(solve_pixel(req_pixel_column, req_pixel_row));
      end
   end

   // Compare every accepted result with the oldest prediction.
   always @(posedge clock) begin
      outcome_t w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outcomes.size() == 0) begin
            report_mismatch("unexpected result", 0, 1);
         end else begin
            w = expected_outcomes.pop_front();
            if (rsp_converged !== w.conv) report_mismatch("converged", w.conv, rsp_converged);
            if (rsp_root_index !== w.root) report_mismatch("root_index", w.root, rsp_root_index);
            if (rsp_iteration_count !== w.count)
               report_mismatch("iteration_count", w.count, rsp_iteration_count);
         end
      end
   end

   // Result side back-pressure: runs of stall, mostly short, a few long.
   int stall_left = 0;
   int free_left = 0;
   always @(posedge clock) begin
      if (calm_phase) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (free_left > 0) begin
         free_left <= free_left - 1;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b0;
         free_left <= $urandom_range(0, 12);
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 80)
                                                   : $urandom_range(0, 3);
      end
   end

   function automatic int pick_gap();
      int sel;
      sel = $urandom_range(0, 9);
      if (calm_phase || sel < 6) return 0;
      if (sel < 9) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Hand one request over; valid stays high for a following request.
   task automatic send_pixel(input logic [11:0] col, input logic [11:0] row,
                             input logic typed, input outcome_t want);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_column <= col;
      req_pixel_row <= row;
      req_typed <= typed;
      req_want <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Write one register; csr_valid is left high for a following write.
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input logic [47:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Write the registers that differ from the shadow copy, or all of them.
   task automatic apply_config(input solver_cfg_t c, input bit all);
      if (all || c.order != cfg_now.order)
         write_reg(CSR_ORDER, {44'($urandom), c.order});
      if (all || c.max_iter != cfg_now.max_iter)
         write_reg(CSR_MAX_ITER, {38'($urandom), c.max_iter});
      if (all || c.tol != cfg_now.tol)
         write_reg(CSR_TOLERANCE, {1'($urandom), c.tol});
      if (all || c.floor_mag != cfg_now.floor_mag)
         write_reg(CSR_DERIV_FLR, {1'($urandom), c.floor_mag});
      if (all || c.x_org != cfg_now.x_org) write_reg(CSR_X_ORIGIN, c.x_org);
      if (all || c.y_org != cfg_now.y_org) write_reg(CSR_Y_ORIGIN, c.y_org);
      if (all || c.x_inc != cfg_now.x_inc)
         write_reg(CSR_X_STEP, {1'($urandom), c.x_inc});
      if (all || c.y_inc != cfg_now.y_inc)
         write_reg(CSR_Y_STEP, {1'($urandom), c.y_inc});
      csr_valid <= 1'b0;
      @(posedge clock);
      cfg_now = c;
   endtask

   function automatic logic [46:0] rand_u47();
      return 47'({$urandom, $urandom});
   endfunction

   // Random settings: mostly a view of the roots with short limits, sometimes extremes.
   function automatic solver_cfg_t random_config();
      solver_cfg_t c;
      int sel;
      sel = $urandom_range(0, 19);
      if (sel < 2) c.order = 4'd0;
      else if (sel < 4) c.order = 4'($urandom_range(9, 15));
      else c.order = 4'($urandom_range(1, 8));
      c.tol = ($urandom_range(0, 9) == 0) ? 47'd0 : 47'($urandom_range(1 << 20, 1 << 29));
      c.max_iter = 10'($urandom_range(1, 24));
      sel = $urandom_range(0, 11);
      if (sel == 0) c.max_iter = 10'd0;
      if (sel == 1) begin
         c.max_iter = 10'd1023;
         c.tol = U47_MAX;
      end
      sel = $urandom_range(0, 9);
      c.floor_mag = (sel == 0) ? U47_MAX : (sel == 1) ? 47'd0 : 47'($urandom_range(0, 5000));
      c.x_org = 48'(s64_t'({$urandom, 1'b0}) - (64'sd1 <<< 33));
      c.y_org = 48'(s64_t'({$urandom, 1'b0}) - (64'sd1 <<< 32));
      c.x_inc = 47'($urandom_range(1 << 18, 1 << 22));
      c.y_inc = 47'($urandom_range(1 << 18, 1 << 22));
      sel = $urandom_range(0, 11);
      if (sel == 0) begin
         c.x_org = {1'b1, 47'($urandom)};
         c.x_inc = rand_u47();
      end
      if (sel == 1) begin
         c.y_org = {1'b0, rand_u47()};
         c.y_inc = U47_MAX;
      end
      if (sel == 2) begin
         c.x_inc = 47'd0;
         c.y_inc = 47'd0;
      end
      return c;
   endfunction

   // Directed table, then random phases.
   initial begin
      solver_cfg_t d, c;
      outcome_t none;
      none = '0;
      for (int n = 1; n <= 8; n++)
         for (int k = 0; k < n; k++)
            make_root(k, n, unit_re[(n - 1) * n / 2 + k], unit_im[(n - 1) * n / 2 + k]);
      d = '{4'd3, 10'd100, 47'd4295, 47'd1, -48'sd8589934592, 48'sd8589934592,
            47'd16793574, 47'd16793574};
      cfg_now = d;

      // Defaults and pixel extremes.
      dir_rows[0] = '{d, 12'd0, 12'd0, 1'b0, none};
      dir_rows[1] = '{d, 12'd4095, 12'd4095, 1'b0, none};
      dir_rows[2] = '{d, 12'd2048, 12'd1024, 1'b0, none};
      // Zero iteration limit.
      c = d; c.max_iter = 10'd0;
      dir_rows[3] = '{c, 12'd100, 12'd200, 1'b1, '{1'b0, 3'd0, 10'd0}};
      // Start exactly on a root.
      c = d; c.order = 4'd1; c.x_org = 48'(ONE_Q); c.y_org = 48'sd0;
      dir_rows[4] = '{c, 12'd0, 12'd0, 1'b1, '{1'b1, 3'd0, 10'd0}};
      c.order = 4'd2; c.x_org = -48'(ONE_Q);
      dir_rows[5] = '{c, 12'd0, 12'd0, 1'b1, '{1'b1, 3'd1, 10'd0}};
      // Zero derivative at the origin, even with no floor.
      c = d; c.x_org = 48'sd0; c.y_org = 48'sd0; c.floor_mag = 47'd0;
      dir_rows[6] = '{c, 12'd0, 12'd0, 1'b1, '{1'b0, 3'd0, 10'd0}};
      // Derivative below a huge floor.
      c = d; c.floor_mag = U47_MAX;
      dir_rows[7] = '{c, 12'd0, 12'd0, 1'b1, '{1'b0, 3'd0, 10'd0}};
      // Timeout with zero tolerance.
      c = d; c.order = 4'd1; c.tol = 47'd0; c.floor_mag = 47'd0; c.max_iter = 10'd5;
      c.x_org = 48'(3 * ONE_Q); c.y_org = 48'(ONE_Q);
      dir_rows[8] = '{c, 12'd0, 12'd0, 1'b1, '{1'b0, 3'd0, 10'd5}};
      // Order zero behaves as order one.
      c = d; c.order = 4'd0; c.x_org = 48'(ONE_Q); c.y_org = 48'sd0;
      dir_rows[9] = '{c, 12'd0, 12'd0, 1'b1, '{1'b1, 3'd0, 10'd0}};
      // Order above the maximum behaves as the maximum; the last root index.
      c = d; c.order = 4'd15; c.max_iter = 10'd30;
      c.x_org = 48'sd3037000500; c.y_org = -48'sd3037000500; c.tol = 47'd1 << 26;
      dir_rows[10] = '{c, 12'd0, 12'd0, 1'b0, none};
      c.order = 4'd8;
      dir_rows[11] = '{c, 12'd3, 12'd5, 1'b0, none};
      // Largest limit with a tolerance that always hits the first root.
      c = d; c.max_iter = 10'd1023; c.tol = U47_MAX;
      dir_rows[12] = '{c, 12'd4095, 12'd0, 1'b1, '{1'b1, 3'd0, 10'd0}};
      // Saturation of the start point.
      c = d; c.max_iter = 10'd10; c.x_org = 48'sh7FFF_FFFF_FFFF; c.x_inc = U47_MAX;
      dir_rows[13] = '{c, 12'd4095, 12'd0, 1'b0, none};
      c.x_org = 48'sh8000_0000_0000; c.y_org = 48'sh7FFF_FFFF_FFFF; c.y_inc = U47_MAX;
      c.x_inc = 47'd0;
      dir_rows[14] = '{c, 12'd0, 12'd4095, 1'b0, none};
      // Zero steps and the remaining orders.
      c = d; c.order = 4'd4; c.x_inc = 47'd0; c.y_inc = 47'd0;
      c.x_org = 48'sd1288490189; c.y_org = 48'sd4724464026;
      dir_rows[15] = '{c, 12'd777, 12'd333, 1'b0, none};
      c = d; c.max_iter = 10'd30; c.order = 4'd5;
      dir_rows[16] = '{c, 12'd1500, 12'd900, 1'b0, none};
      c.order = 4'd6;
      dir_rows[17] = '{c, 12'd2500, 12'd2600, 1'b0, none};
      c.order = 4'd7;
      dir_rows[18] = '{c, 12'd1234, 12'd3001, 1'b0, none};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A write to an unused index must leave every register alone.
      write_reg(CSR_SPARE, 48'hFFFF_FFFF_FFFF);
      apply_config(d, 1'b1);

      for (int i = 0; i < N_DIRECTED; i++) begin
         if (dir_rows[i].cfg != cfg_now) begin
            wait_idle();
            apply_config(dir_rows[i].cfg, 1'b0);
         end
         send_pixel(dir_rows[i].col, dir_rows[i].row, dir_rows[i].typed, dir_rows[i].want);
      end

      // Random phases; the first runs without idling, one waits out each result.
      for (int ph = 0; ph < N_PHASES; ph++) begin
         wait_idle();
         calm_phase = (ph == 0);
         apply_config(random_config(), 1'b1);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (ph == 3) wait_idle();
            send_pixel(12'($urandom), 12'($urandom), 1'b0, none);
         end
         calm_phase = 1'b0;
      end

      wait_idle();
      repeat (100) @(posedge clock);
      if (error_count == 0 && expected_outcomes.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
